@@ rtl/ist_pkg.sv @@
// Shared constants and types for the ignition spark timer.
package ist_pkg;

    // Spark table size and recharge delay counter width.
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int DELAY_WIDTH = 16;

    // Dwell count saturates here; also the recharge offset in startup mode.
    localparam logic [7:0] DWELL_LIMIT = 8'd239;

    // Item kinds carried on the input tuser bit.
    localparam logic CMD_TICK        = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    // Payload widths on the stream ports.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef logic [7:0]             tick8_t;
    typedef logic [DELAY_WIDTH-1:0] delay_t;

endpackage

@@ rtl/ignition_spark_timer.sv @@
// Ignition spark timer: debounce, dwell timing, spark table and recharge delay.
//
// Every input word is either a timer tick or a spark table write (tuser).
// The block accepts one word per clock unless the output stalls, and returns
// exactly one result word for each, in order. All timing state lives in flops
// except the spark table, a 256 x 8 synchronous memory with one write and one
// read port. The table is read only when the shutter leaves the sensor; its
// registered read data lands in the next cycle and is forwarded to the logic
// for that cycle, so back-to-back ticks never stall. One output register holds
// the result word; a new word is taken whenever that register is empty or being
// drained. The table has no reset and must be written before the first shutter
// exit that reads an entry.
module ignition_spark_timer
    import ist_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: debounce_count.
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] hall_level, [1] engine_stop, [2] overrun_one, [3] overrun_two,
    // [4] coil_off_set, [12:5] table_index, [20:13] table_value, [23:21] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic                  s_tuser,
    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] coil_drive, [1] led_level, [2] sensor_state, [18:3] period_ticks,
    // [19] period_valid, [23:20] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic [TABLE_AW:0] DEPTH_V = (TABLE_AW + 1)'(TABLE_DEPTH);

    // Unpacked input fields.
    logic   hall_level;
    logic   engine_stop;
    logic   overrun_one;
    logic   overrun_two;
    logic   coil_off_set;
    tick8_t table_index;
    tick8_t table_value;

    assign hall_level   = s_tdata[0];
    assign engine_stop  = s_tdata[1];
    assign overrun_one  = s_tdata[2];
    assign overrun_two  = s_tdata[3];
    assign coil_off_set = s_tdata[4];
    assign table_index  = s_tdata[12:5];
    assign table_value  = s_tdata[20:13];

    // State registers.
    tick8_t       debounce_count_reg;
    logic         sensor_reg,     sensor_next;
    tick8_t       run_reg,        run_next;
    logic         last_in_reg,    last_in_next;
    logic         overflow_reg,   overflow_next;
    logic         coil_off_reg,   coil_off_next;
    tick8_t       dwell_reg,      dwell_next;
    logic [15:0]  total_reg,      total_next;
    tick8_t       spark_time_reg;
    delay_t       delay_reg,      delay_next;
    logic         coil_reg,       coil_next;
    logic         led_reg,        led_next;
    logic [15:0]  period_reg,     period_next;
    logic         spark_pend_reg;
    logic         out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic   accept;
    logic   is_tick;
    logic   exit_event;
    logic   period_valid;
    tick8_t spark_time_cur;

    // Spark table memory.
    tick8_t spark_table [TABLE_DEPTH];
    tick8_t table_rdata_reg;
    logic   table_we;
    logic   table_re;

    // Handshake: take a word when the output register is free or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == CMD_TICK);

    // The spark time fetched on the last exit is forwarded for one cycle.
    assign spark_time_cur = spark_pend_reg ? table_rdata_reg : spark_time_reg;

    // Table port controls.
    assign table_we = accept && (s_tuser == CMD_TABLE_WRITE)
                      && ({1'b0, table_index} < DEPTH_V);
    assign table_re = accept && is_tick && exit_event;

    always_ff @(posedge clk)
    begin
        if (table_we)
        begin
            spark_table[table_index[TABLE_AW-1:0]] <= table_value;
        end
        if (table_re)
        begin
            table_rdata_reg <= spark_table[dwell_reg[TABLE_AW-1:0]];
        end
    end

    // Next-state logic for one tick.
    always_comb
    begin
        tick8_t run_inc;
        tick8_t dwell_inc;
        tick8_t offset;

        run_inc   = run_reg + 8'd1;
        dwell_inc = dwell_reg + 8'd1;
        offset    = (spark_time_cur == 8'd0) ? DWELL_LIMIT : spark_time_cur;

        sensor_next     = sensor_reg;
        run_next        = run_reg;
        last_in_next    = last_in_reg;
        overflow_next   = overflow_reg;
        coil_off_next   = coil_off_reg | coil_off_set;
        dwell_next      = dwell_reg;
        total_next      = total_reg;
        delay_next      = delay_reg;
        coil_next       = coil_reg;
        led_next        = led_reg;
        period_next     = period_reg;
        exit_event      = 1'b0;
        period_valid    = 1'b0;

        // Run-length debounce of the raw sensor level.
        if (hall_level != sensor_reg)
        begin
            run_next = run_inc;
            if (run_inc == debounce_count_reg)
            begin
                sensor_next = !sensor_reg;
                run_next    = 8'd0;
            end
        end
        else
        begin
            run_next = 8'd0;
        end

        // Shutter entry, dwell, exit and recharge phases.
        if (sensor_next)
        begin
            if (!last_in_reg)
            begin
                if (!engine_stop && !overrun_one && !overrun_two)
                begin
                    coil_next = 1'b1;
                end
                total_next    = 16'd0;
                dwell_next    = 8'd0;
                last_in_next  = 1'b1;
                overflow_next = 1'b0;
                coil_off_next = 1'b0;
            end
            else
            begin
                led_next = 1'b0;
                if (total_reg != 16'hFFFF)
                begin
                    total_next = total_reg + 16'd1;
                end
                if (!overflow_reg)
                begin
                    dwell_next = dwell_inc;
                    if (dwell_inc >= DWELL_LIMIT)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (spark_time_cur != 8'd0 && dwell_inc == spark_time_cur)
                    begin
                        coil_next = 1'b0;
                    end
                end
            end
        end
        else if (last_in_reg)
        begin
            coil_next    = 1'b0;
            last_in_next = 1'b0;
            delay_next   = DELAY_WIDTH'(dwell_reg) + DELAY_WIDTH'(offset);
            period_next  = total_reg;
            exit_event   = 1'b1;
            period_valid = 1'b1;
        end
        else
        begin
            led_next   = 1'b1;
            delay_next = delay_reg - DELAY_WIDTH'(1);
            if (delay_next == '0 && !engine_stop && !coil_off_next
                && !overrun_one && !overrun_two)
            begin
                coil_next = 1'b1;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_count_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            debounce_count_reg <= cfg_wdata;
        end
    end

    // Timer state, updated on accepted ticks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_reg   <= 1'b0;
            run_reg      <= 8'd0;
            last_in_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            coil_off_reg <= 1'b0;
            dwell_reg    <= 8'd0;
            total_reg    <= 16'd0;
            delay_reg    <= '0;
            coil_reg     <= 1'b0;
            led_reg      <= 1'b1;
            period_reg   <= 16'd0;
        end
        else if (accept && is_tick)
        begin
            sensor_reg   <= sensor_next;
            run_reg      <= run_next;
            last_in_reg  <= last_in_next;
            overflow_reg <= overflow_next;
            coil_off_reg <= coil_off_next;
            dwell_reg    <= dwell_next;
            total_reg    <= total_next;
            delay_reg    <= delay_next;
            coil_reg     <= coil_next;
            led_reg      <= led_next;
            period_reg   <= period_next;
        end
    end

    // Spark time register and the one-cycle forwarding flag for table reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spark_time_reg <= 8'd0;
            spark_pend_reg <= 1'b0;
        end
        else
        begin
            if (spark_pend_reg)
            begin
                spark_time_reg <= table_rdata_reg;
            end
            spark_pend_reg <= table_re;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (is_tick)
            begin
                out_data_reg <= {4'd0, period_valid, period_next,
                                 sensor_next, led_next, coil_next};
            end
            else
            begin
                out_data_reg <= {4'd0, 1'b0, period_reg,
                                 sensor_reg, led_reg, coil_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The dwell count never passes its saturation limit.
    a_dwell_limit: assert property (@(posedge clk) disable iff (!rst_n)
        dwell_reg <= DWELL_LIMIT)
        else $error("dwell count above limit");

    // A pending table read always follows a shutter exit.
    a_pend_after_exit: assert property (@(posedge clk) disable iff (!rst_n)
        spark_pend_reg |-> (!sensor_reg && !last_in_reg))
        else $error("spark table read pending outside exit");

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

    // A reported period always comes with the shutter out of the sensor.
    a_period_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[19]) |-> !out_data_reg[2])
        else $error("period reported while shutter in sensor");

endmodule

@@ dv/tb_top.sv @@
// Self-checking stream testbench for the ignition spark timer.
module tb_top;
    import ist_pkg::*;

    // Long receiver hold-off, and cycles with no word moving on either side before the run is abandoned.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_PRINTED     = 40;

    // One input word: cmd travels on tuser, everything else on tdata.
    typedef struct packed {
        logic       cmd;
        logic [7:0] table_value;
        logic [7:0] table_index;
        logic       coil_off_set;
        logic       overrun_two;
        logic       overrun_one;
        logic       engine_stop;
        logic       hall_level;
    } timer_word_t;

    // One result word, packed in the same order as m_tdata[19:0].
    typedef struct packed {
        logic        period_valid;
        logic [15:0] period_ticks;
        logic        sensor_state;
        logic        led_level;
        logic        coil_drive;
    } timer_out_t;

    // Full timing state of the block, spark table and its written marks included.
    typedef struct packed {
        logic [TABLE_DEPTH-1:0][7:0] spark_mem;
        logic [TABLE_DEPTH-1:0]      spark_loaded;
        logic                        sensor;
        tick8_t                      run_len;
        logic                        shutter_in;
        logic                        dwell_sat;
        logic                        coil_off;
        tick8_t                      dwell;
        logic [15:0]                 dwell_total;
        tick8_t                      spark_time;
        delay_t                      recharge;
        logic                        coil;
        logic                        led;
        logic [15:0]                 last_period;
    } timer_state_t;

    // State right after reset: everything clear, LED pin high.
    function automatic timer_state_t reset_state();
        timer_state_t st;
        st = '0;
        st.led = 1'b1;
        return st;
    endfunction

    // Advances the timer by one word and returns the result it produces.
    // empty_read flags a shutter exit that fetches a spark time never loaded.
    function automatic void advance_timer(inout timer_state_t st, input timer_word_t w,
                                          input tick8_t debounce, output timer_out_t res,
                                          output logic empty_read);
        res = '0;
        empty_read = 1'b0;
        if (w.cmd == CMD_TABLE_WRITE)
        begin
            st.spark_mem[w.table_index] = w.table_value;
            st.spark_loaded[w.table_index] = 1'b1;
        end
        else
        begin
            if (w.coil_off_set)
                st.coil_off = 1'b1;

            // Run-length debounce of the raw sensor level.
            if (w.hall_level != st.sensor)
            begin
                st.run_len = st.run_len + 8'd1;
                if (st.run_len == debounce)
                begin
                    st.sensor = ~st.sensor;
                    st.run_len = '0;
                end
            end
            else
                st.run_len = '0;

            if (st.sensor && !st.shutter_in)
            begin
                // Shutter entry: charge unless inhibited, restart the dwell.
                if (!w.engine_stop && !w.overrun_one && !w.overrun_two)
                    st.coil = 1'b1;
                st.dwell_total = '0;
                st.dwell = '0;
                st.shutter_in = 1'b1;
                st.dwell_sat = 1'b0;
                st.coil_off = 1'b0;
            end
            else if (st.sensor)
            begin
                // Dwell: count ticks and fire when the spark time is reached.
                st.led = 1'b0;
                if (st.dwell_total != 16'hFFFF)
                    st.dwell_total = st.dwell_total + 16'd1;
                if (!st.dwell_sat)
                begin
                    st.dwell = st.dwell + 8'd1;
                    if (st.dwell >= DWELL_LIMIT)
                        st.dwell_sat = 1'b1;
                    if (st.spark_time != 0 && st.dwell == st.spark_time)
                        st.coil = 1'b0;
                end
            end
            else if (st.shutter_in)
            begin
                // Shutter exit: fire, load the recharge delay, fetch the next spark time.
                st.coil = 1'b0;
                st.shutter_in = 1'b0;
                st.recharge = delay_t'(st.dwell) +
                              (st.spark_time == 0 ? delay_t'(DWELL_LIMIT)
                                                  : delay_t'(st.spark_time));
                empty_read = !st.spark_loaded[st.dwell];
                st.spark_time = st.spark_mem[st.dwell];
                st.last_period = st.dwell_total;
                res.period_valid = 1'b1;
            end
            else
            begin
                // Outside the shutter the delay runs down and recharges the coil at zero.
                st.led = 1'b1;
                st.recharge = st.recharge - delay_t'(1);
                if (st.recharge == 0 && !w.engine_stop && !st.coil_off &&
                    !w.overrun_one && !w.overrun_two)
                    st.coil = 1'b1;
            end
        end
        res.coil_drive = st.coil;
        res.led_level = st.led;
        res.sensor_state = st.sensor;
        res.period_ticks = st.last_period;
    endfunction

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [7:0]            cfg_wdata = 8'd0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    ignition_spark_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Words waiting to be sent, and results the block still owes.
    timer_word_t  word_backlog[$];
    timer_out_t   predicted_outputs[$];
    timer_state_t model_state = reset_state();
    timer_state_t gen_state = reset_state();
    timer_word_t  offered_word = '0;
    tick8_t       debounce_setting = 8'd3;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   words_queued = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    int   stall_asked = 0;
    int   stall_done = 0;
    int   stall_left = 0;
    logic in_taken = 1'b0;
    int   ticks_seen = 0;
    int   writes_seen = 0;
    int   periods_seen = 0;
    int   sparks_seen = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (fail_count < MAX_PRINTED)
            $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        fail_count++;
    endtask

    function automatic timer_word_t tick_word(logic hall, logic stop, logic ov1, logic ov2,
                                              logic off);
        timer_word_t w;
        w.cmd = CMD_TICK;
        w.hall_level = hall;
        w.engine_stop = stop;
        w.overrun_one = ov1;
        w.overrun_two = ov2;
        w.coil_off_set = off;
        // The table fields are don't-care on a tick; keep them moving.
        w.table_index = 8'($urandom);
        w.table_value = 8'($urandom);
        return w;
    endfunction

    function automatic timer_word_t write_word(tick8_t index, tick8_t value);
        timer_word_t w;
        w = timer_word_t'($bits(timer_word_t)'($urandom));
        w.cmd = CMD_TABLE_WRITE;
        w.table_index = index;
        w.table_value = value;
        return w;
    endfunction

    // Mostly startup or short spark times, so that sparks fire within short dwells.
    function automatic tick8_t pick_spark_time();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return 8'd0;
        if (roll < 75)
            return 8'($urandom_range(1, 40));
        return 8'($urandom_range(0, 255));
    endfunction

    // Queues one word. A shutter exit that would read an empty table slot gets
    // that slot loaded first, so the table is never read before it is written.
    function automatic void enqueue_word(timer_word_t w);
        timer_state_t trial;
        timer_out_t   unused;
        logic         empty_read;
        timer_word_t  fill;
        trial = gen_state;
        advance_timer(trial, w, debounce_setting, unused, empty_read);
        if (empty_read)
        begin
            fill = write_word(gen_state.dwell, pick_spark_time());
            advance_timer(gen_state, fill, debounce_setting, unused, empty_read);
            word_backlog.push_back(fill);
            words_queued++;
            trial = gen_state;
            advance_timer(trial, w, debounce_setting, unused, empty_read);
        end
        gen_state = trial;
        word_backlog.push_back(w);
        words_queued++;
    endfunction

    function automatic void push_tick(logic hall);
        enqueue_word(tick_word(hall, $urandom_range(99) < 4, $urandom_range(99) < 4,
                               $urandom_range(99) < 4, $urandom_range(99) < 4));
    endfunction

    // One shutter pass with sensor glitches, random inhibits and stray table writes.
    function automatic void shutter_pass(int in_len, int out_len);
        for (int k = 0; k < in_len + out_len; k++)
        begin
            if ($urandom_range(99) < 3)
                enqueue_word(write_word(8'($urandom), pick_spark_time()));
            push_tick((k < in_len) ^ ($urandom_range(99) < 5));
        end
    endfunction

    // A clean shutter pass with no glitches and no inhibits.
    function automatic void steady_pass(int in_len, int out_len);
        for (int k = 0; k < in_len + out_len; k++)
            enqueue_word(tick_word(k < in_len, 1'b0, 1'b0, 1'b0, 1'b0));
    endfunction

    // Mostly well-formed shutter passes, some long enough to saturate the dwell,
    // with bursts of fully random words mixed in.
    function automatic void random_traffic(int count);
        int goal;
        goal = words_queued + count;
        while (words_queued < goal)
        begin
            case ($urandom_range(19))
                0, 1:
                    repeat ($urandom_range(1, 8))
                        enqueue_word(timer_word_t'($bits(timer_word_t)'($urandom)));
                2:
                    shutter_pass($urandom_range(200, 280), $urandom_range(5, 40));
                default:
                    shutter_pass($urandom_range(1, 40), $urandom_range(1, 30));
            endcase
        end
    endfunction

    task automatic wait_drained();
        while (results_seen != words_queued)
            @(negedge clk);
    endtask

    // The debounce register is written only with nothing in flight.
    task automatic set_debounce(tick8_t value);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        debounce_setting = value;
    endtask

    // Input side: offers the next queued word once the current one has been taken.
    always @(negedge clk)
    begin : word_driver
        timer_word_t w;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (in_taken || !s_tvalid)
        begin
            if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = word_backlog.pop_front();
                offered_word = w;
                s_tvalid <= 1'b1;
                s_tuser <= w.cmd;
                s_tdata <= {3'b000, w.table_value, w.table_index, w.coil_off_set,
                            w.overrun_two, w.overrun_one, w.engine_stop, w.hall_level};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output side: random backpressure, plus a long hold-off on request.
    always @(negedge clk)
    begin : result_sink
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (stall_asked != stall_done)
        begin
            stall_done = stall_asked;
            stall_left = HOLD_OFF_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Checks each result against the oldest prediction, then predicts for the
    // word accepted at this edge.
    always @(posedge clk)
    begin : scoreboard
        timer_out_t got;
        timer_out_t want;
        timer_out_t next_out;
        logic       empty_read;
        logic       coil_was;
        in_taken <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = timer_out_t'(m_tdata[19:0]);
            results_seen++;
            if (predicted_outputs.size() == 0)
                report_mismatch("word with nothing expected", got.period_ticks, 16'd0);
            else
            begin
                want = predicted_outputs.pop_front();
                if (got.coil_drive != want.coil_drive)
                    report_mismatch("coil_drive", 16'(got.coil_drive), 16'(want.coil_drive));
                if (got.led_level != want.led_level)
                    report_mismatch("led_level", 16'(got.led_level), 16'(want.led_level));
                if (got.sensor_state != want.sensor_state)
                    report_mismatch("sensor_state", 16'(got.sensor_state),
                                    16'(want.sensor_state));
                if (got.period_ticks != want.period_ticks)
                    report_mismatch("period_ticks", got.period_ticks, want.period_ticks);
                if (got.period_valid != want.period_valid)
                    report_mismatch("period_valid", 16'(got.period_valid),
                                    16'(want.period_valid));
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            coil_was = model_state.coil;
            advance_timer(model_state, offered_word, debounce_setting, next_out, empty_read);
            predicted_outputs.push_back(next_out);
            if (offered_word.cmd == CMD_TICK)
                ticks_seen++;
            else
                writes_seen++;
            if (next_out.period_valid)
                periods_seen++;
            if (coil_was && !next_out.coil_drive)
                sparks_seen++;
        end
    end

    // Abandons the run when no word moves on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Run stalled: no word moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Sender mostly busy, receiver mostly idle; debounce of one sample.
        send_idle_pct = 11;
        recv_idle_pct = 82;
        set_debounce(8'd1);

        // First tick after reset: the recharge delay wraps from zero.
        enqueue_word(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(write_word(8'd255, 8'd255));
        enqueue_word(write_word(8'd0, 8'd0));
        enqueue_word(write_word(8'd1, 8'd1));
        enqueue_word(write_word(8'd2, 8'd2));
        // Entry in the same tick as a coil-off request clears it; startup dwell never fires.
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // Entry under engine stop, then the dwell reaches the spark time.
        enqueue_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // Each overrun inhibit on its own; the first pass exits at dwell zero.
        enqueue_word(tick_word(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // A charged pass that sparks at dwell one.
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        enqueue_word(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        // Coil-off request outside the shutter, then all inhibits together.
        enqueue_word(tick_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        enqueue_word(tick_word(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        random_traffic(120);
        // Hold the receiver off while the sender keeps offering.
        stall_asked++;

        // Sender mostly idle, receiver mostly ready; reset debounce value.
        wait_drained();
        send_idle_pct = 82;
        recv_idle_pct = 11;
        set_debounce(8'd3);
        random_traffic(80);
        // Leave the shutter out of the sensor before the wide debounce counts.
        steady_pass(0, 4);

        // No idling: the widest debounce count to enter the shutter, then a zero
        // count that wraps the run counter before the exit; the dwell saturates.
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_debounce(8'd255);
        steady_pass(258, 2);
        set_debounce(8'd0);
        steady_pass(0, 258);
        set_debounce(8'd2);
        random_traffic(40);

        wait_drained();
        repeat (20) @(negedge clk);
        $display("Covered %0d ticks, %0d table writes, %0d period reports and %0d sparks,",
                 ticks_seen, writes_seen, periods_seen, sparks_seen);
        $display("under debounce counts 1, 3, 255, 0 and 2 with stalls on both sides.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
